[rtl/smbl_pkg.sv]
package smbl_pkg;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_LOCATE = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_PIECE    = 4'd0,
		ST_EMPTY    = 4'd1,
		ST_APPENDED = 4'd2,
		ST_MERGED   = 4'd3,
		ST_CLEARED  = 4'd4,
		ST_VIEW     = 4'd5,
		ST_BEYOND   = 4'd6,
		ST_ZERO     = 4'd7,
		ST_OVERLAP  = 4'd8,
		ST_OVERFLOW = 4'd9,
		ST_FULL     = 4'd10,
		ST_INVALID  = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_WALK
	} fsm_t;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned VIEW_W = 16;

endpackage

[rtl/span_map_build_and_locate.sv]
// Clear, append and every rejected request load their one result at the first edge after the
// beat is taken. A locate walks the span RAM through its single read port, one entry per
// cycle unless the result port stalls: the exec state reads entry 0 and the walk state
// checks each registered entry. A stalled result port holds those results and the walk.
// Reset (arst_n low, asynchronous) leaves an empty, valid mapping and view_id 0; the span
// RAM is not cleared, since only entries below the fill count are ever read.
module span_map_build_and_locate #(
	parameter int unsigned MAX_SPANS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [smbl_pkg::VIEW_W-1:0] cfg_wr_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  mode,
	input  logic [smbl_pkg::ADDR_W-1:0] span_start,
	input  logic [smbl_pkg::ADDR_W-1:0] span_length,
	input  logic [smbl_pkg::VIEW_W-1:0] range_view_id,
	input  logic [smbl_pkg::ADDR_W-1:0] range_start,
	input  logic [smbl_pkg::ADDR_W-1:0] range_length,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [3:0]                  status,
	output logic [smbl_pkg::ADDR_W-1:0] source_start,
	output logic [smbl_pkg::ADDR_W-1:0] piece_length,
	output logic                        last
);

	localparam int unsigned IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_SPANS + 1);
	localparam int unsigned AW    = smbl_pkg::ADDR_W;

	smbl_pkg::fsm_t state_q, state_d;

	// Captured request.
	logic [1:0]                  mode_q;
	logic [AW-1:0]               span_start_q, span_length_q;
	logic [smbl_pkg::VIEW_W-1:0] range_view_id_q;
	logic [AW-1:0]               range_start_q, range_length_q;

	// Mapping state kept in flops; the spans themselves live in the RAM.
	logic [smbl_pkg::VIEW_W-1:0] view_q;
	logic [CNT_W-1:0]            count_q, count_d;
	logic [AW-1:0]               logical_q, logical_d;
	logic                        map_valid_q, map_valid_d;
	logic [AW-1:0]               tail_start_q, tail_start_d;
	logic [AW-1:0]               tail_len_q, tail_len_d;
	logic [AW-1:0]               prev_end_q, prev_end_d;

	// Walk state.
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [AW-1:0]    skip_q, skip_d;
	logic [AW-1:0]    need_q, need_d;
	logic [AW-1:0]    remain_q, remain_d;

	// Result register.
	logic                 rsp_valid_q;
	smbl_pkg::status_t    rsp_status_q;
	logic [AW-1:0]        rsp_src_q, rsp_len_q;
	logic                 rsp_last_q;

	logic                 emit;
	smbl_pkg::status_t    e_status;
	logic [AW-1:0]        e_src, e_len;
	logic                 e_last;
	logic                 out_free;

	logic                 wr_en, rd_en;
	logic [IDX_W-1:0]     wr_addr, rd_addr, idx_next;
	logic [2*AW-1:0]      wr_data, rd_data;
	logic [CNT_W-1:0]     tail_idx;

	logic          span_c, log_c, rng_c, skip_b;
	logic [AW-1:0] span_end, log_sum, rng_end, merged_len, skip_left;
	logic [AW-1:0] ent_start, ent_len, need_left, piece_start, piece_len;
	logic          has_piece, is_last, tail_exists, table_full;

	smbl_ram #(
		.WIDTH(2 * AW),
		.DEPTH(MAX_SPANS)
	) u_span_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign req_ready = (state_q == smbl_pkg::FSM_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign {span_c, span_end} = {1'b0, span_start_q} + {1'b0, span_length_q};
	assign {log_c, log_sum}   = {1'b0, logical_q} + {1'b0, span_length_q};
	assign {rng_c, rng_end}   = {1'b0, range_start_q} + {1'b0, range_length_q};
	assign merged_len         = tail_len_q + span_length_q;
	assign tail_exists        = (count_q != '0);
	assign table_full         = (count_q >= CNT_W'(MAX_SPANS));
	assign tail_idx           = count_q - CNT_W'(1);

	// The walk tracks bits still to skip, bits up to the range end, and bits still owed.
	// An entry ends the walk once its length covers everything up to the range end.
	assign ent_start            = rd_data[2*AW-1:AW];
	assign ent_len              = rd_data[AW-1:0];
	assign {skip_b, skip_left}  = {1'b0, skip_q} - {1'b0, ent_len};
	assign has_piece            = skip_b;
	assign is_last              = (ent_len >= need_q);
	assign need_left            = need_q - ent_len;
	assign piece_start          = ent_start + skip_q;
	assign piece_len            = is_last ? remain_q : (ent_len - skip_q);
	assign idx_next             = idx_q + IDX_W'(1);

	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		e_status    = smbl_pkg::ST_PIECE;
		e_src       = '0;
		e_len       = '0;
		e_last      = 1'b1;
		wr_en       = 1'b0;
		wr_addr     = count_q[IDX_W-1:0];
		wr_data     = {span_start_q, span_length_q};
		rd_en       = 1'b0;
		rd_addr     = '0;
		count_d     = count_q;
		logical_d   = logical_q;
		map_valid_d = map_valid_q;
		tail_start_d = tail_start_q;
		tail_len_d  = tail_len_q;
		prev_end_d  = prev_end_q;
		idx_d       = idx_q;
		skip_d      = skip_q;
		need_d      = need_q;
		remain_d    = remain_q;

		unique case (state_q)
			smbl_pkg::FSM_IDLE: begin
				if (req_valid) begin
					state_d = smbl_pkg::FSM_EXEC;
				end
			end

			smbl_pkg::FSM_EXEC: begin
				if (out_free) begin
					state_d = smbl_pkg::FSM_IDLE;
					unique case (mode_q)
						smbl_pkg::MODE_CLEAR: begin
							emit        = 1'b1;
							e_status    = smbl_pkg::ST_CLEARED;
							count_d     = '0;
							logical_d   = '0;
							map_valid_d = 1'b1;
						end
						smbl_pkg::MODE_APPEND: begin
							emit = 1'b1;
							if (!map_valid_q) begin
								e_status = smbl_pkg::ST_INVALID;
							end else if (span_length_q == '0) begin
								e_status    = smbl_pkg::ST_ZERO;
								map_valid_d = 1'b0;
							end else if (span_c || log_c) begin
								e_status    = smbl_pkg::ST_OVERFLOW;
								map_valid_d = 1'b0;
							end else if (tail_exists && (span_start_q < prev_end_q)) begin
								e_status    = smbl_pkg::ST_OVERLAP;
								map_valid_d = 1'b0;
							end else if (tail_exists && (span_start_q == prev_end_q)) begin
								// Contiguous with the last entry: grow it in place.
								e_status   = smbl_pkg::ST_MERGED;
								wr_en      = 1'b1;
								wr_addr    = tail_idx[IDX_W-1:0];
								wr_data    = {tail_start_q, merged_len};
								tail_len_d = merged_len;
								prev_end_d = span_end;
								logical_d  = log_sum;
							end else if (table_full) begin
								e_status    = smbl_pkg::ST_FULL;
								map_valid_d = 1'b0;
							end else begin
								e_status     = smbl_pkg::ST_APPENDED;
								wr_en        = 1'b1;
								tail_start_d = span_start_q;
								tail_len_d   = span_length_q;
								prev_end_d   = span_end;
								count_d      = count_q + CNT_W'(1);
								logical_d    = log_sum;
							end
						end
						smbl_pkg::MODE_LOCATE: begin
							emit = 1'b1;
							if (!map_valid_q) begin
								e_status = smbl_pkg::ST_INVALID;
							end else if (rng_c) begin
								e_status = smbl_pkg::ST_OVERFLOW;
							end else if (range_view_id_q != view_q) begin
								e_status = smbl_pkg::ST_VIEW;
							end else if (rng_end > logical_q) begin
								e_status = smbl_pkg::ST_BEYOND;
							end else if (range_length_q == '0) begin
								e_status = smbl_pkg::ST_EMPTY;
							end else begin
								emit     = 1'b0;
								rd_en    = 1'b1;
								rd_addr  = '0;
								idx_d    = '0;
								skip_d   = range_start_q;
								need_d   = rng_end;
								remain_d = range_length_q;
								state_d  = smbl_pkg::FSM_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end

			smbl_pkg::FSM_WALK: begin
				if (!has_piece) begin
					skip_d  = skip_left;
					need_d  = need_left;
					idx_d   = idx_next;
					rd_en   = 1'b1;
					rd_addr = idx_next;
				end else if (out_free) begin
					emit     = 1'b1;
					e_status = smbl_pkg::ST_PIECE;
					e_src    = piece_start;
					e_len    = piece_len;
					e_last   = is_last;
					if (is_last) begin
						state_d = smbl_pkg::FSM_IDLE;
					end else begin
						skip_d   = '0;
						need_d   = need_left;
						remain_d = need_left;
						idx_d    = idx_next;
						rd_en    = 1'b1;
						rd_addr  = idx_next;
					end
				end
			end

			default: begin
				state_d = smbl_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smbl_pkg::FSM_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			logical_q   <= '0;
			map_valid_q <= 1'b1;
			view_q      <= '0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= emit ? 1'b1 : (rsp_valid_q && !rsp_ready);
			count_q     <= count_d;
			logical_q   <= logical_d;
			map_valid_q <= map_valid_d;
			if (cfg_wr_en) begin
				view_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			mode_q          <= mode;
			span_start_q    <= span_start;
			span_length_q   <= span_length;
			range_view_id_q <= range_view_id;
			range_start_q   <= range_start;
			range_length_q  <= range_length;
		end
		tail_start_q <= tail_start_d;
		tail_len_q   <= tail_len_d;
		prev_end_q   <= prev_end_d;
		idx_q        <= idx_d;
		skip_q       <= skip_d;
		need_q       <= need_d;
		remain_q     <= remain_d;
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_src_q    <= e_src;
			rsp_len_q    <= e_len;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign source_start = rsp_src_q;
	assign piece_length = rsp_len_q;
	assign last         = rsp_last_q;

	// The walk must end before it runs past the filled part of the table.
	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smbl_pkg::FSM_WALK) |-> (CNT_W'(idx_q) < count_q))
		else $error("span walk beyond filled entries");

	// The table is never written while a locate is reading it.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smbl_pkg::FSM_WALK) |-> !wr_en)
		else $error("span RAM written during walk");

	// A new result is only loaded when the previous one has left or is leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten");

	// The fill count only changes by a clear or by one append.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != count_d) |-> ((count_d == '0) || (count_d == count_q + CNT_W'(1))))
		else $error("fill count jumped");

endmodule

[rtl/smbl_ram.sv]
module smbl_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
